[design/srpc_pkg.sv]
// Shared types and codes for the servo response packet checker.
package srpc_pkg;

   // Input action codes
   localparam logic [1:0] ACT_START   = 2'd0;
   localparam logic [1:0] ACT_BYTE    = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   // Verdict codes
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_HDR_TIMEOUT  = 4'd1;
   localparam logic [3:0] ST_BYTE1        = 4'd2;
   localparam logic [3:0] ST_BYTE2        = 4'd3;
   localparam logic [3:0] ST_ID           = 4'd4;
   localparam logic [3:0] ST_CMD          = 4'd5;
   localparam logic [3:0] ST_SIZE         = 4'd6;
   localparam logic [3:0] ST_DATA_TIMEOUT = 4'd7;
   localparam logic [3:0] ST_CS1          = 4'd8;
   localparam logic [3:0] ST_CS2          = 4'd9;
   localparam logic [3:0] ST_OFFSET       = 4'd10;
   localparam logic [3:0] ST_LENGTH       = 4'd11;

   // Configuration register indexes
   localparam logic [2:0] REG_SERVO_ID    = 3'd0;
   localparam logic [2:0] REG_REQUEST_CMD = 3'd1;
   localparam logic [2:0] REG_DATA_LEN    = 3'd2;
   localparam logic [2:0] REG_READ_CHECK  = 3'd3;
   localparam logic [2:0] REG_READ_ADDR   = 3'd4;
   localparam logic [2:0] REG_READ_LEN    = 3'd5;

   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] REPLY_FLAG  = 8'h40;
   localparam logic [7:0] CHECK_MASK  = 8'hFE;
   localparam logic [7:0] HEADER_LEN  = 8'd7;
   localparam logic [2:0] HEADER_LAST = 3'd6;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEAD,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] byte_index;
      logic [3:0] status;
      logic       verdict_last;
   } result_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

[design/srpc_rsp_queue.sv]
// Four-entry result queue taking up to two beats per cycle and giving one.
module srpc_rsp_queue
   import srpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  result_type push_first,
   input  result_type push_second,
   input  logic       pop,
   output logic       not_empty,
   output logic       has_room,
   output result_type head
);

   result_type  entry_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  wr_next;

   assign wr_next   = wr_ptr_ff + 2'd1;
   assign not_empty = (count_ff != 3'd0);
   // room for two beats
   assign has_room  = (count_ff <= 3'd2);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push.first} + {1'b0, push.second};
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {2'b00, push.first} + {2'b00, push.second} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push.second) begin
         entry_ff[wr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/servo_response_packet_checker.sv]
// Top level of the servo response packet checker.
//
// Request channel (req_valid/req_stall): one beat per action. Start arms the
// checker, a byte beat carries one received byte, a timeout beat aborts the
// reply in progress. Response channel (rsp_valid/rsp_stall): one beat per
// data byte (verdict_last low, with its index) and one final verdict beat per
// reply (verdict_last high, status code). The last data byte yields two beats.
// Configuration is written through csr_write/csr_index/csr_data, by the user
// only while idle; the block does not enforce this. Results are registered
// in the four-entry result queue. Throughput: one request beat per cycle;
// the queue takes a beat whenever at least two entries are free, so req_stall
// rises only once the receiver stalled long enough to leave one entry free.
// Reset clears the phase, counters, checksum, echo flags, the result queue and
// loads the register defaults (id 0, command 7, ten data bytes, no read check).
// While rsp_stall is high the head beat holds and results back up in the
// queue, then req_stall holds off further requests.
module servo_response_packet_checker
   import srpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_byte_index,
   output logic [3:0] rsp_status,
   output logic       rsp_verdict_last,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   logic [7:0] servo_id_ff, request_cmd_ff, data_len_ff, read_addr_ff, read_len_ff;
   logic       read_check_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [1:0] echo_ff, echo_in;
   logic [7:0] header_ff [7];
   logic       hdr_we;

   logic       accept;
   logic       q_room;
   logic       pop;
   push_type   push;
   result_type res_first, res_second, q_head;

   logic [7:0] reply_cmd, reply_size;
   logic [7:0] count_next;
   logic [3:0] hdr_st;

   function automatic logic [3:0] final_check(
      input logic [7:0] chk1,
      input logic [7:0] chk2,
      input logic [7:0] size,
      input logic [7:0] id,
      input logic [7:0] cmd,
      input logic [7:0] xsum,
      input logic       rd_chk,
      input logic [1:0] echo
   );
      logic [7:0] c;
      c = size ^ id ^ cmd ^ xsum;
      priority if (chk1 != (c & CHECK_MASK)) return ST_CS1;
      else if (chk2 != (~c & CHECK_MASK)) return ST_CS2;
      else if (rd_chk && echo[0]) return ST_OFFSET;
      else if (rd_chk && echo[1]) return ST_LENGTH;
      else return ST_OK;
   endfunction

   assign accept     = req_valid && !req_stall;
   assign req_stall  = !q_room;
   assign pop        = rsp_valid && !rsp_stall;
   assign reply_cmd  = request_cmd_ff | REPLY_FLAG;
   assign reply_size = HEADER_LEN + data_len_ff;
   assign count_next = byte_count_ff + 8'd1;

   // header checks, byte six is the current byte and needs none of these
   always_comb begin
      priority if (header_ff[0] != SYNC_BYTE) hdr_st = ST_BYTE1;
      else if (header_ff[1] != SYNC_BYTE) hdr_st = ST_BYTE2;
      else if (header_ff[3] != servo_id_ff) hdr_st = ST_ID;
      else if (header_ff[4] != reply_cmd) hdr_st = ST_CMD;
      else if (header_ff[2] != reply_size) hdr_st = ST_SIZE;
      else hdr_st = ST_OK;
   end

   always_comb begin
      logic [3:0] st;
      logic [7:0] xsum;
      logic [1:0] echo;
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      echo_in        = echo_ff;
      hdr_we         = 1'b0;
      push           = '0;
      res_first      = '0;
      res_second     = '0;
      st             = ST_OK;
      xsum           = running_xor_ff ^ req_rx_byte;
      echo           = echo_ff;
      if (accept) begin
         unique case (req_action)
            ACT_START: begin
               phase_in       = PH_HEAD;
               byte_count_in  = '0;
               running_xor_in = '0;
               echo_in        = '0;
            end
            ACT_TIMEOUT: begin
               if (phase_ff == PH_HEAD || phase_ff == PH_DATA) begin
                  phase_in               = PH_IDLE;
                  push.first             = 1'b1;
                  res_first.verdict_last = 1'b1;
                  res_first.status = (phase_ff == PH_HEAD) ? ST_HDR_TIMEOUT : ST_DATA_TIMEOUT;
               end
            end
            ACT_BYTE: begin
               unique case (phase_ff)
                  PH_HEAD: begin
                     hdr_we        = 1'b1;
                     byte_count_in = count_next;
                     if (byte_count_ff[2:0] == HEADER_LAST) begin
                        st = hdr_st;
                        if (st == ST_OK && data_len_ff == 8'd0) begin
                           st = final_check(header_ff[5], req_rx_byte, reply_size,
                                            servo_id_ff, reply_cmd, running_xor_ff,
                                            read_check_ff, echo_ff);
                        end
                        if (st != ST_OK || data_len_ff == 8'd0) begin
                           phase_in               = PH_IDLE;
                           push.first             = 1'b1;
                           res_first.status       = st;
                           res_first.verdict_last = 1'b1;
                        end else begin
                           phase_in      = PH_DATA;
                           byte_count_in = '0;
                        end
                     end
                  end
                  PH_DATA: begin
                     if (byte_count_ff == 8'd2 && req_rx_byte != read_addr_ff) echo[0] = 1'b1;
                     if (byte_count_ff == 8'd3 && req_rx_byte != read_len_ff) echo[1] = 1'b1;
                     running_xor_in       = xsum;
                     echo_in              = echo;
                     byte_count_in        = count_next;
                     push.first           = 1'b1;
                     res_first.out_byte   = req_rx_byte;
                     res_first.byte_index = byte_count_ff;
                     // last data byte: append the verdict
                     if (count_next >= data_len_ff) begin
                        phase_in                = PH_IDLE;
                        push.second             = 1'b1;
                        res_second.verdict_last = 1'b1;
                        res_second.status = final_check(header_ff[5], header_ff[6], reply_size,
                                                        servo_id_ff, reply_cmd, xsum,
                                                        read_check_ff, echo);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ACT_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         header_ff[byte_count_ff[2:0]] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_count_ff  <= '0;
         running_xor_ff <= '0;
         echo_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
         echo_ff        <= echo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_id_ff    <= 8'd0;
         request_cmd_ff <= 8'd7;
         data_len_ff    <= 8'd10;
         read_check_ff  <= 1'b0;
         read_addr_ff   <= 8'd0;
         read_len_ff    <= 8'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SERVO_ID:    servo_id_ff    <= csr_data;
            REG_REQUEST_CMD: request_cmd_ff <= csr_data;
            REG_DATA_LEN:    data_len_ff    <= csr_data;
            REG_READ_CHECK:  read_check_ff  <= csr_data[0];
            REG_READ_ADDR:   read_addr_ff   <= csr_data;
            REG_READ_LEN:    read_len_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   srpc_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_first  (res_first),
      .push_second (res_second),
      .pop         (pop),
      .not_empty   (rsp_valid),
      .has_room    (q_room),
      .head        (q_head)
   );

   assign rsp_out_byte     = q_head.out_byte;
   assign rsp_byte_index   = q_head.byte_index;
   assign rsp_status       = q_head.status;
   assign rsp_verdict_last = q_head.verdict_last;

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_IDLE |-> !push.first)
      else $error("result produced while idle");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first && !res_first.verdict_last && res_second.verdict_last)
      else $error("bad two-beat result");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEAD |-> byte_count_ff < HEADER_LEN)
      else $error("header count overran");

   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict_last |-> rsp_out_byte == 8'd0 && rsp_byte_index == 8'd0)
      else $error("verdict beat carries data");

endmodule

[verif/tb.sv]
// Self-checking testbench for the servo response packet checker.
module tb;
   import srpc_pkg::*;

   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef enum {
      FLAW_NONE, FLAW_SYNC0, FLAW_SYNC1, FLAW_SIZE, FLAW_ID, FLAW_CMD,
      FLAW_CS1, FLAW_CS2, FLAW_ECHO, FLAW_CUT, FLAW_DROP, FLAW_NOISE
   } flaw_type;

   typedef struct {
      logic [1:0] act;
      logic [7:0] data;
      bit         typed;
      result_type want;
   } plan_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_action;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_byte_index;
   logic [3:0] rsp_status;
   logic       rsp_verdict_last;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [7:0] csr_data;

   // register shadow, reset values
   logic [7:0] cfg_id    = 8'h00;
   logic [7:0] cfg_cmd   = 8'h07;
   logic [7:0] cfg_len   = 8'd10;
   logic       cfg_rchk  = 1'b0;
   logic [7:0] cfg_raddr = 8'h00;
   logic [7:0] cfg_rlen  = 8'h00;

   // reply tracking state
   phase_type  reply_phase = PH_IDLE;
   logic [7:0] seen        = 8'd0;
   logic [7:0] hdr_bytes [7];
   logic [7:0] data_xor    = 8'd0;
   logic [1:0] echo_bad    = 2'b00;

   result_type beats_due [$];
   int         fail_count  = 0;
   int         quiet_cycles = 0;
   bit         tx_idle = 1'b1;
   bit         rx_idle = 1'b1;
   bit         choke   = 1'b0;

   servo_response_packet_checker DUT (.*);

   function automatic result_type verdict(logic [3:0] st);
      return {8'd0, 8'd0, st, 1'b1};
   endfunction

   // reset defaults: id 00, command 47 on the wire, size 11, ten data bytes
   plan_row_type opening_plan [26] = '{
      '{ACT_BYTE,    8'h5A, 1'b0, '0},
      '{ACT_TIMEOUT, 8'h00, 1'b0, '0},
      '{ACT_NONE,    8'hFF, 1'b0, '0},
      '{ACT_START,   8'h00, 1'b0, '0},
      '{ACT_TIMEOUT, 8'h00, 1'b1, verdict(ST_HDR_TIMEOUT)},
      '{ACT_START,   8'hFF, 1'b0, '0},
      '{ACT_BYTE,    8'hFE, 1'b0, '0},
      '{ACT_BYTE,    8'hFF, 1'b0, '0},
      '{ACT_BYTE,    8'h11, 1'b0, '0},
      '{ACT_BYTE,    8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'h47, 1'b0, '0},
      '{ACT_BYTE,    8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'h00, 1'b1, verdict(ST_BYTE1)},
      '{ACT_START,   8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'hFF, 1'b0, '0},
      '{ACT_START,   8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'hFF, 1'b0, '0},
      '{ACT_BYTE,    8'hFF, 1'b0, '0},
      '{ACT_BYTE,    8'h11, 1'b0, '0},
      '{ACT_BYTE,    8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'h47, 1'b0, '0},
      '{ACT_BYTE,    8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'h00, 1'b0, '0},
      '{ACT_BYTE,    8'hFF, 1'b0, '0},
      '{ACT_TIMEOUT, 8'hFF, 1'b1, verdict(ST_DATA_TIMEOUT)}
   };

   function automatic logic [3:0] reply_verdict();
      logic [7:0] sum;
      sum = (HEADER_LEN + cfg_len) ^ cfg_id ^ (cfg_cmd | REPLY_FLAG) ^ data_xor;
      if (hdr_bytes[5] != (sum & CHECK_MASK)) return ST_CS1;
      if (hdr_bytes[6] != (~sum & CHECK_MASK)) return ST_CS2;
      if (cfg_rchk) begin
         if (echo_bad[0]) return ST_OFFSET;
         if (echo_bad[1]) return ST_LENGTH;
      end
      return ST_OK;
   endfunction

   // advance the reply state by one accepted beat and queue its results
   function automatic void follow_reply(logic [1:0] act, logic [7:0] b);
      logic [3:0] st;
      logic [7:0] size_byte;
      size_byte = HEADER_LEN + cfg_len;
      case (act)
         ACT_START: begin
            reply_phase = PH_HEAD;
            seen = 8'd0;
            data_xor = 8'd0;
            echo_bad = 2'b00;
         end
         ACT_TIMEOUT: begin
            if (reply_phase == PH_HEAD) beats_due.push_back(verdict(ST_HDR_TIMEOUT));
            else if (reply_phase == PH_DATA) beats_due.push_back(verdict(ST_DATA_TIMEOUT));
            reply_phase = PH_IDLE;
         end
         ACT_BYTE: begin
            if (reply_phase == PH_HEAD) begin
               hdr_bytes[seen[2:0]] = b;
               seen++;
               if (seen == HEADER_LEN) begin
                  if (hdr_bytes[0] != SYNC_BYTE) st = ST_BYTE1;
                  else if (hdr_bytes[1] != SYNC_BYTE) st = ST_BYTE2;
                  else if (hdr_bytes[3] != cfg_id) st = ST_ID;
                  else if (hdr_bytes[4] != (cfg_cmd | REPLY_FLAG)) st = ST_CMD;
                  else if (hdr_bytes[2] != size_byte) st = ST_SIZE;
                  else if (cfg_len == 8'd0) st = reply_verdict();
                  else st = ST_OK;
                  if (st != ST_OK || cfg_len == 8'd0) begin
                     reply_phase = PH_IDLE;
                     beats_due.push_back(verdict(st));
                  end else begin
                     reply_phase = PH_DATA;
                     seen = 8'd0;
                  end
               end
            end else if (reply_phase == PH_DATA) begin
               data_xor ^= b;
               if (seen == 8'd2 && b != cfg_raddr) echo_bad[0] = 1'b1;
               if (seen == 8'd3 && b != cfg_rlen) echo_bad[1] = 1'b1;
               beats_due.push_back({b, seen, ST_OK, 1'b0});
               seen++;
               if (seen >= cfg_len) begin
                  reply_phase = PH_IDLE;
                  beats_due.push_back(verdict(reply_verdict()));
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_beat(input logic [1:0] act, input logic [7:0] b,
                            input bit typed = 1'b0, input result_type want = '0);
      int gap;
      gap = tx_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      follow_reply(act, b);
      // a typed row replaces the computed verdict with the hand-written one
      if (typed) begin
         void'(beats_due.pop_back());
         beats_due.push_back(want);
      end
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      case (index)
         REG_SERVO_ID:    cfg_id    = value;
         REG_REQUEST_CMD: cfg_cmd   = value;
         REG_DATA_LEN:    cfg_len   = value;
         REG_READ_CHECK:  cfg_rchk  = value[0];
         REG_READ_ADDR:   cfg_raddr = value;
         REG_READ_LEN:    cfg_rlen  = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [7:0] id, cmd, data_bytes,
                                input logic echo_on, input logic [7:0] echo_addr, echo_len);
      write_reg(REG_SERVO_ID, id);
      write_reg(REG_REQUEST_CMD, cmd);
      write_reg(REG_DATA_LEN, data_bytes);
      write_reg(REG_READ_CHECK, {7'd0, echo_on});
      write_reg(REG_READ_ADDR, echo_addr);
      write_reg(REG_READ_LEN, echo_len);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // build a well-formed reply for the current settings, then spoil it as asked
   task automatic send_reply(input flaw_type flaw);
      logic [7:0] pkt [$];
      logic [7:0] body [$];
      logic [7:0] sum, d, flip, size_byte, cmd_byte;
      int         cut, bad_echo, junk;
      size_byte = HEADER_LEN + cfg_len;
      cmd_byte  = cfg_cmd | REPLY_FLAG;
      sum       = size_byte ^ cfg_id ^ cmd_byte;
      bad_echo  = (flaw == FLAW_ECHO) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < cfg_len; i++) begin
         d = 8'($urandom);
         if (i == 2) d = bad_echo[0] ? ~cfg_raddr : cfg_raddr;
         if (i == 3) d = bad_echo[1] ? ~cfg_rlen : cfg_rlen;
         sum ^= d;
         body.push_back(d);
      end
      pkt = {SYNC_BYTE, SYNC_BYTE, size_byte, cfg_id, cmd_byte,
             8'(sum & CHECK_MASK), 8'(~sum & CHECK_MASK)};
      pkt = {pkt, body};
      flip = 8'($urandom_range(1, 255));
      case (flaw)
         FLAW_SYNC0: pkt[0] ^= flip;
         FLAW_SYNC1: pkt[1] ^= flip;
         FLAW_SIZE:  pkt[2] ^= flip;
         FLAW_ID:    pkt[3] ^= flip;
         FLAW_CMD:   pkt[4] ^= flip;
         FLAW_CS1:   pkt[5] ^= flip;
         FLAW_CS2:   pkt[6] ^= flip;
         default: ;
      endcase
      cut = pkt.size();
      if (flaw == FLAW_CUT || flaw == FLAW_DROP) cut = $urandom_range(0, pkt.size() - 1);
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 3)) begin
            junk = $urandom_range(0, 2);
            if (junk == 0) send_beat(ACT_BYTE, 8'($urandom));
            else if (junk == 1) send_beat(ACT_TIMEOUT, 8'($urandom));
            else send_beat(ACT_NONE, 8'($urandom));
         end
      end
      send_beat(ACT_START, 8'($urandom));
      for (int i = 0; i < cut; i++) begin
         if (flaw == FLAW_NOISE && $urandom_range(0, 3) == 0) send_beat(ACT_NONE, 8'($urandom));
         send_beat(ACT_BYTE, pkt[i]);
      end
      if (flaw == FLAW_CUT) send_beat(ACT_TIMEOUT, 8'($urandom));
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: draw a stall per beat, hold off once for a long stretch
   initial begin : receiver
      int gap;
      forever begin
         gap = rx_idle ? $urandom_range(0, 3) : 0;
         if (choke) begin
            gap = HOLD_CYCLES;
            choke = 1'b0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beats_due.size() == 0) begin
            $error("result beat with none due: out_byte %0d index %0d status %0d last %0d",
                   rsp_out_byte, rsp_byte_index, rsp_status, rsp_verdict_last);
            fail_count++;
         end else begin
            want = beats_due.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("byte_index", want.byte_index, rsp_byte_index);
            check_field("status", want.status, rsp_status);
            check_field("verdict_last", want.verdict_last, rsp_verdict_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      int       replies;
      flaw_type flaw;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= ACT_NONE;
      req_rx_byte <= 8'd0;
      csr_write   <= 1'b0;
      csr_index   <= REG_SERVO_ID;
      csr_data    <= 8'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i])
         send_beat(opening_plan[i].act, opening_plan[i].data,
                   opening_plan[i].typed, opening_plan[i].want);
      drain();

      for (int p = 0; p < 6; p++) begin
         tx_idle = (p != 1 && p != 4);
         rx_idle = (p != 2);
         case (p)
            0: load_settings(8'h01, 8'h00, 8'd0, 1'b0, 8'h00, 8'h00);
            1: load_settings(8'hFF, 8'hFF, 8'd3, 1'b1, 8'hFF, 8'h00);
            2: load_settings(8'h00, 8'h3F, 8'd1, 1'b1, 8'h12, 8'h34);
            3: load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(4, 12)), 1'b1,
                             8'($urandom), 8'($urandom));
            4: load_settings(8'h7E, 8'h81, 8'd248, 1'($urandom_range(0, 1)), 8'h00, 8'hFF);
            default: load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)),
                                   1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
         endcase
         replies = (p == 4) ? 1 : 3;
         // long reply with no sender gaps: hold the result side so the queue backs up
         if (p == 4) choke = 1'b1;
         repeat (replies) begin
            flaw = $urandom_range(0, 1) ? FLAW_NONE : flaw_type'($urandom_range(1, FLAW_NOISE));
            if (p == 4) flaw = FLAW_NONE;
            send_reply(flaw);
         end
         drain();
      end

      if (fail_count == 0 && beats_due.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
